// File: rtl/core/tdl_pkg.sv
package tdl_pkg;

	localparam logic [6:0] LEVEL_MAX = 7'd100;
	localparam logic [15:0] TIMER_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		M_IDLE      = 3'd0,
		M_HOLD_WAIT = 3'd1,
		M_RAMP_UP   = 3'd2,
		M_TAP_WAIT  = 3'd3,
		M_CONFIRM   = 3'd4,
		M_RAMP_DOWN = 3'd5,
		M_RELEASE   = 3'd6,
		M_LOCKOUT   = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_FULL_ON    = 3'd1,
		EV_OFF        = 3'd2,
		EV_RAMP_UP    = 3'd3,
		EV_RAMP_DOWN  = 3'd4
	} event_t;

	typedef enum logic [3:0] {
		REG_HOLD_CHECK  = 4'd0,
		REG_TAP_WINDOW  = 4'd1,
		REG_TAP_CONFIRM = 4'd2,
		REG_STEP_PERIOD = 4'd3,
		REG_LOCKOUT     = 4'd4,
		REG_AUTO_IDLE   = 4'd5,
		REG_LUX_HIGH    = 4'd6,
		REG_LUX_LOW     = 4'd7
	} reg_index_t;

	typedef struct packed {
		logic [15:0] hold_check_ticks;
		logic [15:0] tap_window_ticks;
		logic [15:0] tap_confirm_ticks;
		logic [7:0]  step_period_ticks;
		logic [15:0] lockout_ticks;
		logic [15:0] auto_idle_ticks;
		logic [15:0] lux_high;
		logic [15:0] lux_low;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] phase_timer;
		logic [6:0]  level;
		logic [15:0] idle_timer;
		logic        trimmed_up;
		logic        trimmed_down;
	} gest_state_t;

endpackage

// File: rtl/core/tdl_gesture.sv
module tdl_gesture
	import tdl_pkg::*;
#(
	parameter int LUX_STEP = 20
) (
	input  cfg_t        cfg,
	input  gest_state_t cur,
	input  logic        touch,
	input  logic        lux_valid,
	input  logic [15:0] lux_sample,
	output gest_state_t nxt,
	output event_t      ev
);

	localparam logic [6:0] STEP = 7'(LUX_STEP);

	logic [15:0] idle_inc;
	logic [15:0] phase_inc;
	logic [15:0] period;
	logic        done;
	logic [6:0]  lvl_inc;
	logic [6:0]  lvl_dec;
	logic [7:0]  sum_step;
	logic [6:0]  lvl_plus;
	logic [6:0]  lvl_minus;
	logic        lux_between;

	always_comb begin
		idle_inc = (cur.idle_timer != TIMER_MAX) ? cur.idle_timer + 16'd1 : cur.idle_timer;
		phase_inc = cur.phase_timer + 16'd1;
		unique case (cur.mode)
			M_HOLD_WAIT: period = cfg.hold_check_ticks;
			M_TAP_WAIT:  period = cfg.tap_window_ticks;
			M_CONFIRM:   period = cfg.tap_confirm_ticks;
			M_RAMP_UP, M_RAMP_DOWN: period = {8'd0, cfg.step_period_ticks};
			default:     period = cfg.lockout_ticks;
		endcase
		done = phase_inc >= period;
		lvl_inc = (cur.level >= LEVEL_MAX) ? LEVEL_MAX : cur.level + 7'd1;
		lvl_dec = (cur.level == 7'd0) ? 7'd0 : cur.level - 7'd1;
		sum_step = {1'b0, cur.level} + {1'b0, STEP};
		lvl_plus = (sum_step > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum_step[6:0];
		lvl_minus = (cur.level < STEP) ? 7'd0 : cur.level - STEP;
		lux_between = (lux_sample > cfg.lux_low) && (lux_sample < cfg.lux_high);
	end

	always_comb begin
		nxt = cur;
		nxt.idle_timer = idle_inc;
		ev = EV_NONE;
		unique case (cur.mode)
			M_IDLE: begin
				if (touch) begin
					nxt.phase_timer = 16'd0;
					nxt.mode = (cur.level == 7'd0) ? M_HOLD_WAIT : M_TAP_WAIT;
				end else if (lux_valid && idle_inc > cfg.auto_idle_ticks) begin
					if (lux_sample < cfg.lux_low && !cur.trimmed_up && cur.level != 7'd0) begin
						nxt.level = lvl_plus;
						nxt.trimmed_up = 1'b1;
					end else if (lux_sample > cfg.lux_high && !cur.trimmed_down) begin
						nxt.level = lvl_minus;
						nxt.trimmed_down = 1'b1;
					end else if (lux_between && cur.trimmed_up) begin
						nxt.level = lvl_minus;
						nxt.trimmed_up = 1'b0;
					end else if (lux_between && cur.trimmed_down) begin
						nxt.level = lvl_plus;
						nxt.trimmed_down = 1'b0;
					end
				end
			end
			M_HOLD_WAIT: begin
				nxt.phase_timer = phase_inc;
				if (done) begin
					nxt.idle_timer = 16'd0;
					nxt.phase_timer = 16'd0;
					if (touch) begin
						nxt.level = lvl_inc;
						ev = EV_RAMP_UP;
						nxt.mode = M_RAMP_UP;
					end else begin
						nxt.level = LEVEL_MAX;
						ev = EV_FULL_ON;
						nxt.mode = M_IDLE;
					end
				end
			end
			M_TAP_WAIT: begin
				nxt.phase_timer = phase_inc;
				if (done) begin
					nxt.phase_timer = 16'd0;
					nxt.mode = touch ? M_IDLE : M_CONFIRM;
				end
			end
			M_CONFIRM: begin
				nxt.phase_timer = phase_inc;
				if (done) begin
					nxt.idle_timer = 16'd0;
					nxt.phase_timer = 16'd0;
					if (touch) begin
						nxt.level = lvl_dec;
						ev = EV_RAMP_DOWN;
						nxt.mode = M_RAMP_DOWN;
					end else begin
						nxt.level = 7'd0;
						ev = EV_OFF;
						nxt.mode = M_IDLE;
					end
				end
			end
			M_RAMP_UP, M_RAMP_DOWN: begin
				nxt.phase_timer = phase_inc;
				if (done) begin
					nxt.phase_timer = 16'd0;
					if (cur.mode == M_RAMP_UP) begin
						if (touch && cur.level < LEVEL_MAX) nxt.level = lvl_inc;
						else nxt.mode = M_RELEASE;
					end else begin
						if (touch && cur.level != 7'd0) nxt.level = lvl_dec;
						else nxt.mode = M_RELEASE;
					end
				end
			end
			M_RELEASE: begin
				if (!touch) begin
					nxt.phase_timer = 16'd0;
					nxt.mode = (cfg.lockout_ticks == 16'd0) ? M_IDLE : M_LOCKOUT;
				end
			end
			M_LOCKOUT: begin
				nxt.phase_timer = phase_inc;
				if (done) begin
					nxt.phase_timer = 16'd0;
					nxt.mode = M_IDLE;
				end
			end
		endcase
	end

endmodule

// File: rtl/core/tdl_duty.sv
module tdl_duty
	import tdl_pkg::*;
#(
	parameter int RAMP_TICKS = 2
) (
	input  logic [6:0] level,
	input  logic [6:0] duty_cur,
	input  logic [3:0] div_cur,
	output logic [6:0] duty_nxt,
	output logic [3:0] div_nxt
);

	localparam logic [3:0] RAMP = 4'(RAMP_TICKS);

	logic [6:0] target;
	logic [3:0] div_inc;

	always_comb begin
		target = LEVEL_MAX - level;
		div_inc = div_cur + 4'd1;
		duty_nxt = duty_cur;
		div_nxt = 4'd0;
		if (duty_cur != target) begin
			if (div_inc >= RAMP) begin
				// one duty step per ramp period, toward the target
				duty_nxt = (duty_cur < target) ? duty_cur + 7'd1 : duty_cur - 7'd1;
			end else begin
				div_nxt = div_inc;
			end
		end
	end

endmodule

// File: rtl/core/touch_dimmer_with_lux_trim_core.sv
// Touch dimmer with ambient-light trim. Each request is one 1 ms tick (touch level plus an
// optional lux sample) and yields exactly one result: inverted PWM duty, target brightness,
// light_on and a gesture event code. A request goes into an input register and is resolved
// by one pass of the gesture and duty logic, which updates the dimmer state and the result
// register together; while the result side keeps up a new request is taken every cycle, so
// throughput is one request per clock. Registers are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while the block is idle, which the block itself
// does not enforce. Indexes above 7 are ignored.
module touch_dimmer_with_lux_trim_core
	import tdl_pkg::*;
#(
	parameter int LUX_STEP   = 20,
	parameter int RAMP_TICKS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        touch,
	input  logic        lux_valid,
	input  logic [15:0] lux_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  duty,
	output logic [6:0]  brightness,
	output logic        light_on,
	output logic [2:0]  gesture_event
);

	cfg_t        cfg_q;
	logic        valid_s1;
	logic        touch_s1;
	logic        lux_valid_s1;
	logic [15:0] lux_sample_s1;
	gest_state_t state_q;
	gest_state_t state_nxt;
	event_t      ev_nxt;
	event_t      event_q;
	logic [6:0]  duty_q;
	logic [6:0]  duty_nxt;
	logic [3:0]  div_q;
	logic [3:0]  div_nxt;
	logic        out_valid_q;
	logic        advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_check_ticks  <= 16'd300;
			cfg_q.tap_window_ticks  <= 16'd150;
			cfg_q.tap_confirm_ticks <= 16'd50;
			cfg_q.step_period_ticks <= 8'd10;
			cfg_q.lockout_ticks     <= 16'd1000;
			cfg_q.auto_idle_ticks   <= 16'd20000;
			cfg_q.lux_high          <= 16'd300;
			cfg_q.lux_low           <= 16'd30;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HOLD_CHECK:  cfg_q.hold_check_ticks  <= cfg_data;
				REG_TAP_WINDOW:  cfg_q.tap_window_ticks  <= cfg_data;
				REG_TAP_CONFIRM: cfg_q.tap_confirm_ticks <= cfg_data;
				REG_STEP_PERIOD: cfg_q.step_period_ticks <= cfg_data[7:0];
				REG_LOCKOUT:     cfg_q.lockout_ticks     <= cfg_data;
				REG_AUTO_IDLE:   cfg_q.auto_idle_ticks   <= cfg_data;
				REG_LUX_HIGH:    cfg_q.lux_high          <= cfg_data;
				REG_LUX_LOW:     cfg_q.lux_low           <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			touch_s1      <= touch;
			lux_valid_s1  <= lux_valid;
			lux_sample_s1 <= lux_sample;
		end
	end

	tdl_gesture #(
		.LUX_STEP(LUX_STEP)
	) u_gesture (
		.cfg       (cfg_q),
		.cur       (state_q),
		.touch     (touch_s1),
		.lux_valid (lux_valid_s1),
		.lux_sample(lux_sample_s1),
		.nxt       (state_nxt),
		.ev        (ev_nxt)
	);

	tdl_duty #(
		.RAMP_TICKS(RAMP_TICKS)
	) u_duty (
		.level   (state_nxt.level),
		.duty_cur(duty_q),
		.div_cur (div_q),
		.duty_nxt(duty_nxt),
		.div_nxt (div_nxt)
	);

	// state and result advance together; the result holds while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= M_IDLE;
			state_q.phase_timer  <= 16'd0;
			state_q.level        <= 7'd0;
			state_q.idle_timer   <= 16'd0;
			state_q.trimmed_up   <= 1'b0;
			state_q.trimmed_down <= 1'b0;
			duty_q               <= LEVEL_MAX;
			div_q                <= 4'd0;
			event_q              <= EV_NONE;
			out_valid_q          <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				duty_q      <= duty_nxt;
				div_q       <= div_nxt;
				event_q     <= ev_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign duty          = duty_q;
	assign brightness    = state_q.level;
	assign light_on      = state_q.level != 7'd0;
	assign gesture_event = event_q;

endmodule

// File: rtl/core/tdl_checker.sv
module tdl_checker
	import tdl_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] duty,
	input logic [6:0] brightness,
	input logic       light_on,
	input logic [2:0] gesture_event
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(brightness)
			&& $stable(gesture_event))
		else $error("result changed while stalled");

	a_light_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (light_on == (brightness != 7'd0)) && (brightness <= LEVEL_MAX))
		else $error("light_on or brightness inconsistent");

	a_duty_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid || duty == $past(duty)
			|| duty == $past(duty) + 7'd1 || duty == $past(duty) - 7'd1)
		else $error("duty moved by more than one step");

	a_event_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gesture_event != EV_FULL_ON || brightness == LEVEL_MAX)
			&& (gesture_event != EV_OFF || brightness == 7'd0))
		else $error("gesture event does not match brightness");

endmodule

bind touch_dimmer_with_lux_trim_core tdl_checker u_tdl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.duty         (duty),
	.brightness   (brightness),
	.light_on     (light_on),
	.gesture_event(gesture_event)
);

// File: tb/sv/touch_dimmer_checker.sv
module touch_dimmer_checker
	import tdl_pkg::*;
#(
	parameter int LUX_STEP   = 20,
	parameter int RAMP_TICKS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        touch,
	input  logic        lux_valid,
	input  logic [15:0] lux_sample,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [6:0]  duty,
	input  logic [6:0]  brightness,
	input  logic        light_on,
	input  logic [2:0]  gesture_event,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [6:0] duty;
		logic [6:0] brightness;
		logic       light_on;
		event_t     gesture_event;
	} dimmer_out_t;

	dimmer_out_t pending_outputs[$];
	int          mismatch_cnt;

	cfg_t        cfg;
	mode_t       mode;
	logic [15:0] phase_timer;
	logic [6:0]  level;
	logic [6:0]  duty_now;
	logic [3:0]  ramp_div;
	logic [15:0] idle_timer;
	logic        trimmed_up;
	logic        trimmed_down;

	function automatic logic [6:0] clamp_level(input int v);
		if (v < 0) return 7'd0;
		if (v > 100) return LEVEL_MAX;
		return 7'(v);
	endfunction

	function automatic bit phase_elapsed(input logic [15:0] period);
		phase_timer = phase_timer + 16'd1;
		return phase_timer >= period;
	endfunction

	task automatic dimmer_tick(input logic t, input logic lv, input logic [15:0] lux,
			output dimmer_out_t r);
		event_t     ev;
		bit         up;
		bit         between;
		logic [6:0] target;
		ev = EV_NONE;
		if (idle_timer != TIMER_MAX) idle_timer = idle_timer + 16'd1;
		case (mode)
			M_IDLE: begin
				if (t) begin
					phase_timer = '0;
					mode = (level == 7'd0) ? M_HOLD_WAIT : M_TAP_WAIT;
				end else if (lv && idle_timer > cfg.auto_idle_ticks) begin
					// trim rules are tried in order; the flags give hysteresis
					between = lux > cfg.lux_low && lux < cfg.lux_high;
					if (lux < cfg.lux_low && !trimmed_up && level != 7'd0) begin
						level = clamp_level(int'(level) + LUX_STEP);
						trimmed_up = 1'b1;
					end else if (lux > cfg.lux_high && !trimmed_down) begin
						level = clamp_level(int'(level) - LUX_STEP);
						trimmed_down = 1'b1;
					end else if (between && trimmed_up) begin
						level = clamp_level(int'(level) - LUX_STEP);
						trimmed_up = 1'b0;
					end else if (between && trimmed_down) begin
						level = clamp_level(int'(level) + LUX_STEP);
						trimmed_down = 1'b0;
					end
				end
			end
			M_HOLD_WAIT: begin
				if (phase_elapsed(cfg.hold_check_ticks)) begin
					idle_timer = '0;
					phase_timer = '0;
					if (t) begin
						level = clamp_level(int'(level) + 1);
						ev = EV_RAMP_UP;
						mode = M_RAMP_UP;
					end else begin
						level = LEVEL_MAX;
						ev = EV_FULL_ON;
						mode = M_IDLE;
					end
				end
			end
			M_TAP_WAIT: begin
				if (phase_elapsed(cfg.tap_window_ticks)) begin
					phase_timer = '0;
					mode = t ? M_IDLE : M_CONFIRM;
				end
			end
			M_CONFIRM: begin
				if (phase_elapsed(cfg.tap_confirm_ticks)) begin
					idle_timer = '0;
					phase_timer = '0;
					if (t) begin
						level = clamp_level(int'(level) - 1);
						ev = EV_RAMP_DOWN;
						mode = M_RAMP_DOWN;
					end else begin
						level = 7'd0;
						ev = EV_OFF;
						mode = M_IDLE;
					end
				end
			end
			M_RAMP_UP, M_RAMP_DOWN: begin
				if (phase_elapsed({8'd0, cfg.step_period_ticks})) begin
					up = (mode == M_RAMP_UP);
					phase_timer = '0;
					if (t && (up ? level < LEVEL_MAX : level > 7'd0))
						level = clamp_level(int'(level) + (up ? 1 : -1));
					else
						mode = M_RELEASE;
				end
			end
			M_RELEASE: begin
				if (!t) begin
					phase_timer = '0;
					mode = (cfg.lockout_ticks == 16'd0) ? M_IDLE : M_LOCKOUT;
				end
			end
			default: begin
				if (phase_elapsed(cfg.lockout_ticks)) begin
					phase_timer = '0;
					mode = M_IDLE;
				end
			end
		endcase

		// walk the inverted duty one step per RAMP_TICKS toward its target
		target = LEVEL_MAX - level;
		if (duty_now != target) begin
			ramp_div = ramp_div + 4'd1;
			if (ramp_div >= RAMP_TICKS) begin
				ramp_div = '0;
				if (duty_now < target) duty_now = duty_now + 7'd1;
				else duty_now = duty_now - 7'd1;
			end
		end else begin
			ramp_div = '0;
		end

		r.duty = duty_now;
		r.brightness = level;
		r.light_on = (level != 7'd0);
		r.gesture_event = ev;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		dimmer_out_t want;
		if (!arst_n) begin
			cfg = '{16'd300, 16'd150, 16'd50, 8'd10, 16'd1000, 16'd20000, 16'd300, 16'd30};
			mode = M_IDLE;
			phase_timer = '0;
			level = '0;
			duty_now = LEVEL_MAX;
			ramp_div = '0;
			idle_timer = '0;
			trimmed_up = 1'b0;
			trimmed_down = 1'b0;
			pending_outputs.delete();
			mismatch_cnt = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HOLD_CHECK:  cfg.hold_check_ticks = cfg_data;
					REG_TAP_WINDOW:  cfg.tap_window_ticks = cfg_data;
					REG_TAP_CONFIRM: cfg.tap_confirm_ticks = cfg_data;
					REG_STEP_PERIOD: cfg.step_period_ticks = cfg_data[7:0];
					REG_LOCKOUT:     cfg.lockout_ticks = cfg_data;
					REG_AUTO_IDLE:   cfg.auto_idle_ticks = cfg_data;
					REG_LUX_HIGH:    cfg.lux_high = cfg_data;
					REG_LUX_LOW:     cfg.lux_low = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				dimmer_tick(touch, lux_valid, lux_sample, want);
				pending_outputs.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (pending_outputs.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("[%0t] result with no request: duty %0d bright %0d on %0b ev %0d",
							$time, duty, brightness, light_on, gesture_event);
					mismatch_cnt++;
				end else begin
					want = pending_outputs.pop_front();
					if (duty !== want.duty || brightness !== want.brightness ||
							light_on !== want.light_on || gesture_event !== want.gesture_event) begin
						// fields in order: duty, brightness, light_on, event
						if (mismatch_cnt < 10)
							$display("[%0t] mismatch: want %0d %0d %0b %0d, got %0d %0d %0b %0d",
								$time, want.duty, want.brightness, want.light_on,
								want.gesture_event, duty, brightness, light_on, gesture_event);
						mismatch_cnt++;
					end
				end
			end
			mismatches <= mismatch_cnt;
			outstanding <= pending_outputs.size();
		end
	end

endmodule

// File: tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tdl_pkg::*;

	localparam int LUX_STEP       = 20;
	localparam int RAMP_TICKS     = 2;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [3:0] REG_UNUSED_LO = 4'd8;
	localparam logic [3:0] REG_UNUSED_HI = 4'd15;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        touch = 1'b0;
	logic        lux_valid = 1'b0;
	logic [15:0] lux_sample = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  duty;
	logic [6:0]  brightness;
	logic        light_on;
	logic [2:0]  gesture_event;
	int          mismatches;
	int          outstanding;

	// shadow of the timing and lux registers, used only to shape stimulus
	int unsigned hold_t, tapw_t, conf_t, lock_t, idle_t, high_t, low_t;
	int          items_sent = 0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	int          rx_hold = 0;

	touch_dimmer_with_lux_trim_core #(
		.LUX_STEP  (LUX_STEP),
		.RAMP_TICKS(RAMP_TICKS)
	) u_dut (.*);

	touch_dimmer_checker #(
		.LUX_STEP  (LUX_STEP),
		.RAMP_TICKS(RAMP_TICKS)
	) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
		if (rx_hold != 0) begin
			rx_hold--;
		end else if (!rx_calm) begin
			case ($urandom_range(0, 9))
				0, 1, 2: rx_hold = $urandom_range(1, 3);
				3: rx_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 60)
					: $urandom_range(4, 8);
				default: ;
			endcase
		end
		out_ready <= (rx_hold == 0);
	end

	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
			else stalled++;
		end
		$display("tb: done, errors");
		$finish;
	end

	function automatic int unsigned capped(input int unsigned v);
		return (v > 24) ? 24 : v;
	endfunction

	function automatic logic [15:0] pick_lux();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'(low_t);
			3: return 16'(high_t);
			4: return (low_t != 0) ? 16'($urandom_range(0, low_t - 1)) : 16'd0;
			5: return (high_t < 65535) ? 16'($urandom_range(high_t + 1, 65535)) : 16'hFFFF;
			6: return (high_t > low_t + 1) ? 16'($urandom_range(low_t + 1, high_t - 1))
				: 16'($urandom);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_tick(input logic t, input logic lv, input logic [15:0] lux);
		int gap;
		if (tx_calm) begin
			gap = 0;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: gap = 0;
				6, 7, 8: gap = $urandom_range(1, 3);
				default: gap = $urandom_range(10, 60);
			endcase
		end
		if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		touch <= t;
		lux_valid <= lv;
		lux_sample <= lux;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic apply_settings(input int unsigned hc, tw, tc, sp, lk, ai, hi, lo);
		// drain every request before touching the registers
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		write_reg(REG_HOLD_CHECK, 16'(hc));
		write_reg(REG_TAP_WINDOW, 16'(tw));
		write_reg(REG_TAP_CONFIRM, 16'(tc));
		write_reg(REG_STEP_PERIOD, {8'($urandom), 8'(sp)});
		write_reg(REG_LOCKOUT, 16'(lk));
		write_reg(REG_AUTO_IDLE, 16'(ai));
		write_reg(REG_LUX_HIGH, 16'(hi));
		write_reg(REG_LUX_LOW, 16'(lo));
		write_reg(REG_UNUSED_LO, 16'($urandom));
		write_reg(REG_UNUSED_HI, 16'($urandom));
		cfg_we <= 1'b0;
		hold_t = hc & 16'hFFFF;
		tapw_t = tw & 16'hFFFF;
		conf_t = tc & 16'hFFFF;
		lock_t = lk & 16'hFFFF;
		idle_t = ai & 16'hFFFF;
		high_t = hi & 16'hFFFF;
		low_t = lo & 16'hFFFF;
	endtask

	task automatic run_gestures(input int n);
		int stop_at, press_len, rest_len;
		int unsigned hc, tw, cf, lk, ai;
		hc = capped(hold_t);
		tw = capped(tapw_t);
		cf = capped(conf_t);
		lk = capped(lock_t);
		ai = capped(idle_t);
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: begin
					// one press, then a rest with lux samples
					case ($urandom_range(0, 9))
						0, 1, 2: press_len = $urandom_range(1, tw + 2);
						3, 4, 5: press_len = hc + $urandom_range(0, 3);
						6, 7: press_len = $urandom_range(1, 40);
						8: press_len = $urandom_range(1, 6);
						default: press_len = $urandom_range(100, 130);
					endcase
					if (press_len == 0) press_len = 1;
					repeat (press_len)
						if (items_sent < stop_at) send_tick(1'b1, 1'($urandom), 16'($urandom));
					case ($urandom_range(0, 3))
						0: rest_len = $urandom_range(1, cf + 2);
						1: rest_len = lk + $urandom_range(1, 4);
						default: rest_len = $urandom_range(1, ai + lk + 12);
					endcase
					repeat (rest_len)
						if (items_sent < stop_at)
							send_tick(1'b0, ($urandom_range(0, 2) != 0), pick_lux());
				end
				7, 8: repeat ($urandom_range(1, 10))
					if (items_sent < stop_at)
						send_tick(1'($urandom), 1'($urandom), 16'($urandom));
				default: begin
					// hold off until every result is back
					in_valid <= 1'b0;
					@(posedge clk);
					while (outstanding != 0) @(posedge clk);
				end
			endcase
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		apply_settings(2, 2, 2, 1, 0, 0, 300, 30);
		// from off, released before the hold check: full on
		send_tick(1'b1, 1'b0, 16'd0);
		send_tick(1'b0, 1'b0, 16'd0);
		send_tick(1'b0, 1'b1, 16'hFFFF);
		// lux trim: clamp at the top, then both directions and both recoveries
		send_tick(1'b0, 1'b1, 16'd0);
		send_tick(1'b0, 1'b1, 16'hFFFF);
		send_tick(1'b0, 1'b1, 16'd100);
		send_tick(1'b0, 1'b1, 16'd100);
		// tap, release, no second press: off
		send_tick(1'b1, 1'b0, 16'd0);
		send_tick(1'b0, 1'b0, 16'd0);
		send_tick(1'b0, 1'b0, 16'd0);
		send_tick(1'b0, 1'b0, 16'd0);
		send_tick(1'b0, 1'b0, 16'd0);
		// hold from off: ramp up, release with zero lockout
		send_tick(1'b1, 1'b0, 16'd0);
		send_tick(1'b1, 1'b0, 16'd0);
		send_tick(1'b1, 1'b0, 16'd0);
		send_tick(1'b0, 1'b0, 16'd0);
		send_tick(1'b0, 1'b0, 16'd0);
		// still held at the end of the tap window, new window right after
		send_tick(1'b1, 1'b0, 16'd0);
		send_tick(1'b1, 1'b0, 16'd0);
		send_tick(1'b1, 1'b0, 16'd0);
		send_tick(1'b1, 1'b0, 16'd0);
		// release, then press again during confirm: ramp down
		send_tick(1'b0, 1'b0, 16'd0);
		send_tick(1'b0, 1'b0, 16'd0);
		send_tick(1'b1, 1'b0, 16'd0);
		send_tick(1'b1, 1'b0, 16'd0);
		send_tick(1'b0, 1'b0, 16'd0);
		send_tick(1'b0, 1'b0, 16'd0);

		apply_settings(3, 3, 2, 1, 3, 6, 300, 30);
		run_gestures(150);
		apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
		run_gestures(90);
		apply_settings($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 6),
			$urandom_range(1, 4), $urandom_range(0, 8), $urandom_range(0, 20),
			$urandom_range(0, 4000), $urandom_range(0, 2000));
		run_gestures(150);
		apply_settings(65535, 65535, 65535, 255, 65535, 65535, 65535, 65535);
		run_gestures(50);
		apply_settings(2, 4, 3, 2, 5, 10, 1000, 100);
		run_gestures(110);

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
